### rtl/core/blst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blst_pkg
// Shared types and codes of the bounded ordered list.
// ----------------------------------------------------------------------------
package blst_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam logic [2:0] CMD_INS_FRONT = 3'd0;
  localparam logic [2:0] CMD_INS_BACK  = 3'd1;
  localparam logic [2:0] CMD_REM_FRONT = 3'd2;
  localparam logic [2:0] CMD_REM_BACK  = 3'd3;
  localparam logic [2:0] CMD_REM_VALUE = 3'd4;
  localparam logic [2:0] CMD_DUMP      = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] item;
    logic [4:0]         count;
    logic               last;
  } res_t;

endpackage

### rtl/core/bounded_ordered_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_ordered_list
// Ordered list of up to CAPACITY signed words kept in a ring store, with
// front/back insert and remove, remove by value, and dump.
// ----------------------------------------------------------------------------
//  channel   signals                           carries
//  command   cmd_valid / cmd_ready             cmd, value
//  result    res_valid / res_ready             status, item, count, last
//
//  Insert and remove at either end move the sequencer to its done state,
//  from which the result word is registered. Remove by value reads the ring
//  store one position a cycle, and compaction follows the read stream.
//  Dump gives one word per cycle while res_ready is high, after its first read.
//  Reset clears the state, head, count and control flags; the store holds no
//  reset value. A stalled result word holds in the output register; no new
//  command is taken until the current one has passed all its words to that register.
// ----------------------------------------------------------------------------
module bounded_ordered_list #(
  parameter int CAPACITY = blst_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] value,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [1:0]         status,
  output logic signed [31:0] item,
  output logic [4:0]         count,
  output logic               last
);

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic               step_valid;
  logic               step_ready;
  blst_pkg::res_t     step_res;
  logic               mem_we;
  logic [PW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;
  logic               mem_re;
  logic [PW-1:0]      mem_raddr;
  logic signed [31:0] mem_rdata;

  blst_ctrl #(
    .CAPACITY (CAPACITY),
    .PW       (PW),
    .CW       (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .value      (value),
    .step_valid (step_valid),
    .step_ready (step_ready),
    .step_res   (step_res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  blst_mem #(
    .DEPTH (CAPACITY),
    .AW    (PW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: takes a new word when it is empty or the current one leaves.
  assign step_ready = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step_ready) begin
      res_valid <= step_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_ready && step_valid) begin
      status <= step_res.status;
      item   <= step_res.item;
      count  <= step_res.count;
      last   <= step_res.last;
    end
  end

endmodule

### rtl/core/blst_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blst_mem
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module blst_mem #(
  parameter int DEPTH = blst_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic signed [31:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic signed [31:0] rdata
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/blst_addr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blst_addr
// Ring address unit: maps a list position to a store address.
// ----------------------------------------------------------------------------
module blst_addr #(
  parameter int CAPACITY = blst_pkg::CAPACITY_DEF,
  parameter int PW       = $clog2(CAPACITY)
) (
  input  logic [PW-1:0] head,
  input  logic [PW-1:0] ofs,
  output logic [PW-1:0] phys
);

  localparam logic [PW:0] CapW = (PW + 1)'(CAPACITY);

  logic [PW:0] sum;
  logic [PW:0] wrapped;

  // Both operands stay below the capacity, so one subtract folds the sum.
  assign sum     = {1'b0, head} + {1'b0, ofs};
  assign wrapped = sum - CapW;
  assign phys    = (sum >= CapW) ? wrapped[PW-1:0] : sum[PW-1:0];

endmodule

### rtl/core/blst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blst_ctrl
// Command sequencer: keeps head and count, walks the store for search,
// compaction and dump through the shared ring address unit.
// ----------------------------------------------------------------------------
module blst_ctrl #(
  parameter int CAPACITY = blst_pkg::CAPACITY_DEF,
  parameter int PW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] value,
  output logic               step_valid,
  input  logic               step_ready,
  output blst_pkg::res_t     step_res,
  output logic               mem_we,
  output logic [PW-1:0]      mem_waddr,
  output logic signed [31:0] mem_wdata,
  output logic               mem_re,
  output logic [PW-1:0]      mem_raddr,
  input  logic signed [31:0] mem_rdata
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DEMIT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  state_t             state, state_next;
  logic [PW-1:0]      head, head_next;
  logic [CW-1:0]      entry_count, entry_count_next;
  logic [CW-1:0]      idx, idx_next;
  logic [CW-1:0]      ridx, ridx_next;
  logic               rv, rv_next;
  logic               found, found_next;
  logic [PW-1:0]      addr_q1, addr_q1_next;
  logic [PW-1:0]      addr_q2, addr_q2_next;
  logic signed [31:0] val, val_next;
  logic [1:0]         status, status_next;

  logic [PW-1:0]      ofs;
  logic [PW-1:0]      phys;
  logic               is_full;
  logic               is_empty;
  logic [CW-1:0]      last_pos;
  logic               issue;
  logic               match;
  logic               end_here;
  logic [CW+4:0]      count_ext;

  blst_addr #(
    .CAPACITY (CAPACITY),
    .PW       (PW)
  ) u_addr (
    .head (head),
    .ofs  (ofs),
    .phys (phys)
  );

  assign is_full   = (entry_count >= CapC);
  assign is_empty  = (entry_count == '0);
  assign last_pos  = entry_count - 1'b1;
  assign issue     = (idx < entry_count);
  assign match     = (mem_rdata == val);
  assign end_here  = (ridx == last_pos);
  assign count_ext = {5'b0, entry_count};

  assign cmd_ready  = (state == S_IDLE);
  assign step_valid = (state == S_DONE) || (state == S_DEMIT);

  always_comb begin
    step_res.status = (state == S_DONE) ? status : blst_pkg::ST_OK;
    step_res.item   = (state == S_DEMIT) ? mem_rdata : 32'sd0;
    step_res.count  = count_ext[4:0];
    step_res.last   = (state == S_DONE) || (idx == last_pos);
  end

  always_comb begin
    state_next       = state;
    head_next        = head;
    entry_count_next = entry_count;
    idx_next         = idx;
    ridx_next        = ridx;
    rv_next          = 1'b0;
    found_next       = found;
    addr_q1_next     = addr_q1;
    addr_q2_next     = addr_q2;
    val_next         = val;
    status_next      = status;
    ofs              = '0;
    mem_we           = 1'b0;
    mem_waddr        = phys;
    mem_wdata        = value;
    mem_re           = 1'b0;
    mem_raddr        = phys;

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          status_next = blst_pkg::ST_OK;
          state_next  = S_DONE;
          case (cmd)
            blst_pkg::CMD_INS_FRONT: begin
              ofs = PW'(CAPACITY - 1);
              if (is_full) begin
                status_next = blst_pkg::ST_FULL;
              end else begin
                mem_we           = 1'b1;
                head_next        = phys;
                entry_count_next = entry_count + 1'b1;
              end
            end
            blst_pkg::CMD_INS_BACK: begin
              ofs = PW'(entry_count);
              if (is_full) begin
                status_next = blst_pkg::ST_FULL;
              end else begin
                mem_we           = 1'b1;
                entry_count_next = entry_count + 1'b1;
              end
            end
            blst_pkg::CMD_REM_FRONT: begin
              ofs = PW'(1);
              if (is_empty) begin
                status_next = blst_pkg::ST_EMPTY;
              end else begin
                head_next        = phys;
                entry_count_next = last_pos;
              end
            end
            blst_pkg::CMD_REM_BACK: begin
              if (is_empty) begin
                status_next = blst_pkg::ST_EMPTY;
              end else begin
                entry_count_next = last_pos;
              end
            end
            blst_pkg::CMD_REM_VALUE: begin
              if (is_empty) begin
                status_next = blst_pkg::ST_EMPTY;
              end else begin
                val_next   = value;
                idx_next   = '0;
                found_next = 1'b0;
                state_next = S_SCAN;
              end
            end
            blst_pkg::CMD_DUMP: begin
              if (is_empty) begin
                status_next = blst_pkg::ST_EMPTY;
              end else begin
                mem_re     = 1'b1;
                idx_next   = '0;
                state_next = S_DEMIT;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Reads run one position ahead of the compare. Once the match is
        // found, each later word moves down into the address read before it.
        ofs          = PW'(idx);
        mem_re       = issue;
        rv_next      = issue;
        ridx_next    = idx;
        addr_q1_next = phys;
        addr_q2_next = addr_q1;
        if (issue) begin
          idx_next = idx + 1'b1;
        end
        mem_waddr = addr_q2;
        mem_wdata = mem_rdata;
        if (rv) begin
          mem_we = found;
          if (found || match) begin
            found_next = 1'b1;
            if (end_here) begin
              entry_count_next = last_pos;
              status_next      = blst_pkg::ST_OK;
              state_next       = S_DONE;
            end
          end else if (end_here) begin
            status_next = blst_pkg::ST_NOTFOUND;
            state_next  = S_DONE;
          end
        end
      end

      S_DEMIT: begin
        ofs = PW'(idx + 1'b1);
        if (step_ready) begin
          if (idx == last_pos) begin
            state_next = S_IDLE;
          end else begin
            mem_re   = 1'b1;
            idx_next = idx + 1'b1;
          end
        end
      end

      S_DONE: begin
        if (step_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head        <= '0;
      entry_count <= '0;
      rv          <= 1'b0;
      found       <= 1'b0;
    end else begin
      state       <= state_next;
      head        <= head_next;
      entry_count <= entry_count_next;
      rv          <= rv_next;
      found       <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    ridx    <= ridx_next;
    addr_q1 <= addr_q1_next;
    addr_q2 <= addr_q2_next;
    val     <= val_next;
    status  <= status_next;
  end

endmodule

### rtl/core/blst_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blst_chk
// Port-level checks of the bounded ordered list, bound to the top level.
// ----------------------------------------------------------------------------
module blst_chk #(
  parameter int CAPACITY = blst_pkg::CAPACITY_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input logic [1:0]         status,
  input logic signed [31:0] item,
  input logic [4:0]         count,
  input logic               last
);

  localparam logic [4:0] CapMasked = 5'(CAPACITY);

  // A stalled result word keeps its payload.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(item)
      && $stable(count) && $stable(last))
    else $error("result word changed while stalled");

  // Only a dump gives words that are not the last of their command.
  a_mid_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && !last |-> status == blst_pkg::ST_OK)
    else $error("non-final word without ok status");

  // An empty status always reports an empty list.
  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == blst_pkg::ST_EMPTY |-> count == 5'd0 && item == 32'sd0)
    else $error("empty status with entries or data");

  // A full status always reports a full list.
  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == blst_pkg::ST_FULL |-> count == CapMasked && last)
    else $error("full status with wrong count");

endmodule

bind bounded_ordered_list blst_chk #(
  .CAPACITY (CAPACITY)
) u_blst_chk (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .status    (status),
  .item      (item),
  .count     (count),
  .last      (last)
);
